/* hw/rtl/srle_pkg.sv */
// Shared types and constants for the SGI RLE scanline decoder.
// No dependencies; imported by every module of the block.
package srle_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned COUNT_W   = 7;
   localparam int unsigned POS_W     = 16;
   localparam int unsigned LIT_BIT   = 7;   // high bit of a control byte: literal packet

   typedef enum logic [1:0] {
      MODE_CTRL    = 2'd0,
      MODE_LITERAL = 2'd1,
      MODE_REPEAT  = 2'd2
   } mode_type;

   // One compressed byte after classification by the front stage.
   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               end_of_line;
      logic [COUNT_W-1:0] count;     // low bits, meaningful for control bytes
      logic               literal;   // high bit, meaningful for control bytes
   } item_type;

endpackage

/* hw/rtl/sgi_rle_scanline_decoder.sv */
// Top level of the SGI RLE scanline decoder: front stage, queue, decode stage.
// Depends on srle_pkg, srle_front, srle_queue and srle_back.
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+--------------
//   req     | data_byte[7:0], end_of_line             | in        | valid / stall
//   rsp     | pixel_value, start_x, run_length,       | out       | valid / stall
//           | line_end, line_ok                       |           |
//   csr     | write_data[15:0] (line_width)           | in        | write_enable
//
// One byte transfers per cycle while req_stall is low; its result (if any) passes
// through the front register, then the queue write, then the result register.
// The mode register decides bytes as popped, one per cycle while rsp_stall is low.
// Reset (synchronous, active high) empties the pipeline, sets line_width to 1
// and returns the decoder to expecting a control byte at pixel 0.
// A stall on rsp holds the result register; the queue and the front register absorb
// QUEUE_DEPTH + 1 more bytes before req_stall rises.
module sgi_rle_scanline_decoder
   import srle_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [POS_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_end_of_line,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_pixel_value,
   output logic [POS_W-1:0]    rsp_start_x,
   output logic [COUNT_W-1:0]  rsp_run_length,
   output logic                rsp_line_end,
   output logic                rsp_line_ok
);

   logic [POS_W-1:0] line_width_ff, line_width_in;

   logic     front_valid;
   logic     front_stall;
   item_type front_item;
   logic     queue_valid;
   logic     queue_pop;
   item_type queue_item;

   // Line width register; the user must write it only while idle; the block does not enforce this.
   assign line_width_in = csr_write_enable ? csr_write_data : line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= POS_W'(1);
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   // Accept and classify each byte.
   srle_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_line (req_end_of_line),
      .item_valid      (front_valid),
      .item_stall      (front_stall),
      .item            (front_item)
   );

   // Decouple the input side from result backpressure.
   srle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_stall (front_stall),
      .wr_item  (front_item),
      .rd_valid (queue_valid),
      .rd_pop   (queue_pop),
      .rd_item  (queue_item)
   );

   // Run the mode machine and drive results.
   srle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .line_width      (line_width_ff),
      .item_valid      (queue_valid),
      .item_pop        (queue_pop),
      .item            (queue_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_start_x     (rsp_start_x),
      .rsp_run_length  (rsp_run_length),
      .rsp_line_end    (rsp_line_end),
      .rsp_line_ok     (rsp_line_ok)
   );

endmodule

/* hw/rtl/srle_front.sv */
// Input stage: registers one compressed byte and splits out its control fields.
// Depends on srle_pkg.
module srle_front
   import srle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_end_of_line,
   output logic                item_valid,
   input  logic                item_stall,
   output item_type            item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_stall = valid_ff && item_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in              = 1'b1;
         item_in.data_byte     = req_data_byte;
         item_in.end_of_line   = req_end_of_line;
         item_in.count         = req_data_byte[COUNT_W-1:0];
         item_in.literal       = req_data_byte[LIT_BIT];
      end else if (!item_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hw/rtl/srle_queue.sv */
// Small FIFO between the front stage and the decode stage.
// Depends on srle_pkg for the entry type.
module srle_queue
   import srle_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_stall,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_pop,
   output item_type rd_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   item_type         mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign wr_stall = (fill_ff == FULL);
   assign rd_valid = (fill_ff != '0);
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_pop && rd_valid;
   assign rd_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + CNT_W'(1);
         2'b01:   fill_in = fill_ff - CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* hw/rtl/srle_back.sv */
// Decode stage: RLE mode machine, pixel position tracking and result register.
// Depends on srle_pkg.
module srle_back
   import srle_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [POS_W-1:0]    line_width,
   input  logic                item_valid,
   output logic                item_pop,
   input  item_type            item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_pixel_value,
   output logic [POS_W-1:0]    rsp_start_x,
   output logic [COUNT_W-1:0]  rsp_run_length,
   output logic                rsp_line_end,
   output logic                rsp_line_ok
);

   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]   pixels_ff, pixels_in;

   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  value_ff, value_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic               end_ff, end_in;
   logic               ok_ff, ok_in;

   logic               have_run;
   logic [COUNT_W-1:0] run_len;
   logic [POS_W-1:0]   room;
   logic [POS_W-1:0]   pixels_new;
   logic [COUNT_W-1:0] count_new;
   mode_type           mode_new;

   assign item_pop = item_valid && (!valid_ff || !rsp_stall);
   assign room     = line_width - pixels_ff;

   // Decode one byte against the current mode.
   always_comb begin
      have_run   = 1'b0;
      run_len    = '0;
      pixels_new = pixels_ff;
      count_new  = count_ff;
      mode_new   = mode_ff;
      if (pixels_ff < line_width) begin
         case (mode_ff)
            MODE_LITERAL: begin
               have_run   = 1'b1;
               run_len    = COUNT_W'(1);
               pixels_new = pixels_ff + POS_W'(1);
               count_new  = count_ff - COUNT_W'(1);
               if (count_new == '0) begin
                  mode_new = MODE_CTRL;
               end
            end
            MODE_REPEAT: begin
               have_run   = 1'b1;
               run_len    = (POS_W'(count_ff) < room) ? count_ff : room[COUNT_W-1:0];
               pixels_new = pixels_ff + POS_W'(run_len);
               count_new  = '0;
               mode_new   = MODE_CTRL;
            end
            MODE_CTRL: begin
               if (item.count != '0) begin
                  count_new = item.count;
                  mode_new  = item.literal ? MODE_LITERAL : MODE_REPEAT;
               end
            end
            default: begin
               mode_new = MODE_CTRL;
            end
         endcase
      end
   end

   // Commit state and load the result register.
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      pixels_in = pixels_ff;
      valid_in  = valid_ff && rsp_stall;
      value_in  = value_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      end_in    = end_ff;
      ok_in     = ok_ff;
      if (item_pop) begin
         mode_in   = mode_new;
         count_in  = count_new;
         pixels_in = pixels_new;
         if (item.end_of_line) begin
            mode_in   = MODE_CTRL;
            count_in  = '0;
            pixels_in = '0;
         end
         valid_in = have_run || item.end_of_line;
         value_in = have_run ? item.data_byte : '0;
         start_in = have_run ? pixels_ff : '0;
         len_in   = run_len;
         end_in   = item.end_of_line;
         ok_in    = item.end_of_line && (pixels_new == line_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_CTRL;
         count_ff  <= '0;
         pixels_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         pixels_ff <= pixels_in;
         valid_ff  <= valid_in;
      end
      value_ff <= value_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      end_ff   <= end_in;
      ok_ff    <= ok_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_value = value_ff;
   assign rsp_start_x     = start_ff;
   assign rsp_run_length  = len_ff;
   assign rsp_line_end    = end_ff;
   assign rsp_line_ok     = ok_ff;

endmodule
